FILE: hdl/wbps_pkg.sv
// ----------------------------------------------------------------------------
// wbps_pkg
// Shared constants and types of the wildcard byte pattern scanner.
// ----------------------------------------------------------------------------
package wbps_pkg;

	localparam int MAX_PATTERN_DEF = 16;
	localparam int ADDR_BITS_DEF   = 48;

	localparam int PAT_REG_BYTES = 16;
	localparam int LEN_W         = 5;
	localparam int MASK_W        = 16;
	localparam int CFG_DATA_W    = 64;
	localparam int CFG_IDX_W     = 2;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_PAT_LOW  = 2'd0,
		CFG_PAT_HIGH = 2'd1,
		CFG_WILDCARD = 2'd2,
		CFG_LENGTH   = 2'd3
	} cfg_idx_t;

	typedef struct packed {
		logic valid;
		logic scan_begin;
	} win_ctl_t;

endpackage

FILE: hdl/wbps_cfg.sv
// ----------------------------------------------------------------------------
// wbps_cfg
// Configuration registers and right-aligned pattern for the window compare.
// ----------------------------------------------------------------------------
module wbps_cfg #(
	parameter int MAX_PATTERN = wbps_pkg::MAX_PATTERN_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_wr_en,
	input  wbps_pkg::cfg_idx_t                    cfg_index,
	input  logic [wbps_pkg::CFG_DATA_W-1:0]       cfg_data,
	output logic [wbps_pkg::LEN_W-1:0]            len,
	output logic [MAX_PATTERN-1:0][7:0]           exp_byte,
	output logic [MAX_PATTERN-1:0]                care
);

	logic [wbps_pkg::CFG_DATA_W-1:0] pat_low_q;
	logic [wbps_pkg::CFG_DATA_W-1:0] pat_high_q;
	logic [wbps_pkg::MASK_W-1:0]     wild_q;
	logic [wbps_pkg::LEN_W-1:0]      len_q;
	logic [wbps_pkg::PAT_REG_BYTES-1:0][7:0] pat_b;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pat_low_q  <= '0;
			pat_high_q <= '0;
			wild_q     <= '0;
			len_q      <= '0;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				wbps_pkg::CFG_PAT_LOW:  pat_low_q  <= cfg_data;
				wbps_pkg::CFG_PAT_HIGH: pat_high_q <= cfg_data;
				wbps_pkg::CFG_WILDCARD: wild_q     <= cfg_data[wbps_pkg::MASK_W-1:0];
				wbps_pkg::CFG_LENGTH:   len_q      <= cfg_data[wbps_pkg::LEN_W-1:0];
				default: ;
			endcase
		end
	end

	assign pat_b = {pat_high_q, pat_low_q};
	assign len   = len_q;

	// window entry j (j bytes back) faces pattern byte len-1-j
	for (genvar j = 0; j < MAX_PATTERN; j++) begin : g_align
		if (j < 32) begin : g_reach
			logic [wbps_pkg::LEN_W-1:0] idx;
			logic                       in_len;
			logic                       in_regs;
			assign in_len  = len_q > wbps_pkg::LEN_W'(j);
			assign idx     = len_q - wbps_pkg::LEN_W'(j + 1);
			assign in_regs = idx < wbps_pkg::LEN_W'(wbps_pkg::PAT_REG_BYTES);
			assign exp_byte[j] = in_regs ? pat_b[idx[3:0]] : 8'd0;
			assign care[j]     = in_len && !(in_regs && wild_q[idx[3:0]]);
		end else begin : g_beyond
			assign exp_byte[j] = 8'd0;
			assign care[j]     = 1'b0;
		end
	end

endmodule

FILE: hdl/wbps_window.sv
// ----------------------------------------------------------------------------
// wbps_window
// Input register: byte window shift line, fill count and word control.
// ----------------------------------------------------------------------------
module wbps_window #(
	parameter int MAX_PATTERN = wbps_pkg::MAX_PATTERN_DEF,
	parameter int ADDR_BITS   = wbps_pkg::ADDR_BITS_DEF,
	parameter int FILL_W      = $clog2(MAX_PATTERN + 1)
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [7:0]                    data_byte,
	input  logic [ADDR_BITS-1:0]          byte_address,
	input  logic                          range_begin,
	input  logic                          scan_begin,
	input  logic                          out_ready,
	output wbps_pkg::win_ctl_t            ctl_s1,
	output logic [MAX_PATTERN-1:0][7:0]   window_s1,
	output logic [FILL_W-1:0]             fill_s1,
	output logic [ADDR_BITS-1:0]          addr_s1
);

	localparam logic [FILL_W-1:0] FILL_MAX = FILL_W'(MAX_PATTERN);

	logic                     accept;
	logic                     clr;
	logic [FILL_W-1:0]        fill_n;

	assign in_stall = ctl_s1.valid && !out_ready;
	assign accept   = in_valid && !in_stall;
	assign clr      = range_begin || scan_begin;

	always_comb begin
		if (clr) begin
			fill_n = FILL_W'(1);
		end else if (fill_s1 == FILL_MAX) begin
			fill_n = FILL_MAX;
		end else begin
			fill_n = fill_s1 + FILL_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1  <= '0;
			fill_s1 <= '0;
		end else if (accept) begin
			ctl_s1.valid      <= 1'b1;
			ctl_s1.scan_begin <= scan_begin;
			fill_s1           <= fill_n;
		end else if (out_ready) begin
			ctl_s1.valid <= 1'b0;
		end
	end

	// advance the window by one byte
	always_ff @(posedge clk) begin
		if (accept) begin
			window_s1[0] <= data_byte;
			addr_s1      <= byte_address;
			for (int k = 1; k < MAX_PATTERN; k++) begin
				window_s1[k] <= window_s1[k-1];
			end
		end
	end

endmodule

FILE: hdl/wbps_match.sv
// ----------------------------------------------------------------------------
// wbps_match
// Window compare, first-match tracking, start address and result register.
// ----------------------------------------------------------------------------
module wbps_match #(
	parameter int MAX_PATTERN = wbps_pkg::MAX_PATTERN_DEF,
	parameter int ADDR_BITS   = wbps_pkg::ADDR_BITS_DEF,
	parameter int FILL_W      = $clog2(MAX_PATTERN + 1)
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  wbps_pkg::win_ctl_t            ctl_s1,
	input  logic [MAX_PATTERN-1:0][7:0]   window_s1,
	input  logic [FILL_W-1:0]             fill_s1,
	input  logic [ADDR_BITS-1:0]          addr_s1,
	input  logic [wbps_pkg::LEN_W-1:0]    len,
	input  logic [MAX_PATTERN-1:0][7:0]   exp_byte,
	input  logic [MAX_PATTERN-1:0]        care,
	output logic                          out_ready,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic                          match_hit,
	output logic [ADDR_BITS-1:0]          match_address,
	output logic                          already_found
);

	localparam int CMP_W = (FILL_W > wbps_pkg::LEN_W) ? FILL_W : wbps_pkg::LEN_W;
	localparam logic [CMP_W-1:0] MAX_C = CMP_W'(MAX_PATTERN);

	logic                   out_valid_q;
	logic                   found_q;
	logic                   hit_q;
	logic                   already_q;
	logic [ADDR_BITS-1:0]   addr_q;
	logic                   advance;
	logic [MAX_PATTERN-1:0] pos_ok;
	logic [CMP_W-1:0]       len_c;
	logic [CMP_W-1:0]       fill_c;
	logic                   len_ok;
	logic                   match;
	logic                   found_in;
	logic                   hit_d;
	logic [ADDR_BITS-1:0]   start;

	assign out_ready = !out_valid_q || !out_stall;
	assign advance   = ctl_s1.valid && out_ready;

	for (genvar j = 0; j < MAX_PATTERN; j++) begin : g_cmp
		assign pos_ok[j] = !care[j] || (window_s1[j] == exp_byte[j]);
	end

	assign len_c    = CMP_W'(len);
	assign fill_c   = CMP_W'(fill_s1);
	assign len_ok   = (len_c != '0) && (len_c <= MAX_C) && (fill_c >= len_c);
	assign match    = len_ok && (&pos_ok);
	assign found_in = ctl_s1.scan_begin ? 1'b0 : found_q;
	assign hit_d    = match && !found_in;
	assign start    = addr_s1 - ADDR_BITS'(len) + ADDR_BITS'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			found_q     <= 1'b0;
		end else begin
			if (advance) begin
				out_valid_q <= 1'b1;
				found_q     <= found_in || hit_d;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			hit_q     <= hit_d;
			already_q <= found_in || hit_d;
			addr_q    <= hit_d ? start : '0;
		end
	end

	assign out_valid     = out_valid_q;
	assign match_hit     = hit_q;
	assign match_address = addr_q;
	assign already_found = already_q;

`ifndef SYNTH
	a_hit_sets_found: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && hit_q |-> already_q)
		else $error("hit reported without found flag");

	a_no_hit_zero_addr: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !hit_q |-> addr_q == '0)
		else $error("address nonzero without hit");

	a_suppress_repeat: assert property (@(posedge clk) disable iff (!arst_n)
		advance && found_q && !ctl_s1.scan_begin |=> !hit_q)
		else $error("second match reported in one scan");

	a_zero_len_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		advance && len == '0 |=> !hit_q)
		else $error("match with zero pattern length");
`endif

endmodule

FILE: hdl/wildcard_byte_pattern_scan.sv
// ----------------------------------------------------------------------------
// wildcard_byte_pattern_scan
// Searches a byte stream for a pattern of up to 16 bytes with per-byte
// wildcards and reports the first match of each scan with its start address.
// Takes one word per cycle unless out_stall holds it back; the input
// register holds the byte window and the result register the compare, start
// address and found flag. range_begin empties the window, scan_begin also
// rearms the search. Write configuration only while no word is in flight.
// ----------------------------------------------------------------------------
module wildcard_byte_pattern_scan #(
	parameter int MAX_PATTERN = wbps_pkg::MAX_PATTERN_DEF,
	parameter int ADDR_BITS   = wbps_pkg::ADDR_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_wr_en,
	input  logic [wbps_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [wbps_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [7:0]                      data_byte,
	input  logic [ADDR_BITS-1:0]            byte_address,
	input  logic                            range_begin,
	input  logic                            scan_begin,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic                            match_hit,
	output logic [ADDR_BITS-1:0]            match_address,
	output logic                            already_found
);

	localparam int FILL_W = $clog2(MAX_PATTERN + 1);

	logic [wbps_pkg::LEN_W-1:0]     len;
	logic [MAX_PATTERN-1:0][7:0]    exp_byte;
	logic [MAX_PATTERN-1:0]         care;
	wbps_pkg::win_ctl_t             ctl_s1;
	logic [MAX_PATTERN-1:0][7:0]    window_s1;
	logic [FILL_W-1:0]              fill_s1;
	logic [ADDR_BITS-1:0]           addr_s1;
	logic                           out_ready;

	wbps_cfg #(
		.MAX_PATTERN(MAX_PATTERN)
	) u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(wbps_pkg::cfg_idx_t'(cfg_index)),
		.cfg_data (cfg_data),
		.len      (len),
		.exp_byte (exp_byte),
		.care     (care)
	);

	wbps_window #(
		.MAX_PATTERN(MAX_PATTERN),
		.ADDR_BITS  (ADDR_BITS),
		.FILL_W     (FILL_W)
	) u_window (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.data_byte   (data_byte),
		.byte_address(byte_address),
		.range_begin (range_begin),
		.scan_begin  (scan_begin),
		.out_ready   (out_ready),
		.ctl_s1      (ctl_s1),
		.window_s1   (window_s1),
		.fill_s1     (fill_s1),
		.addr_s1     (addr_s1)
	);

	wbps_match #(
		.MAX_PATTERN(MAX_PATTERN),
		.ADDR_BITS  (ADDR_BITS),
		.FILL_W     (FILL_W)
	) u_match (
		.clk          (clk),
		.arst_n       (arst_n),
		.ctl_s1       (ctl_s1),
		.window_s1    (window_s1),
		.fill_s1      (fill_s1),
		.addr_s1      (addr_s1),
		.len          (len),
		.exp_byte     (exp_byte),
		.care         (care),
		.out_ready    (out_ready),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.match_hit    (match_hit),
		.match_address(match_address),
		.already_found(already_found)
	);

endmodule
